### hdl/capb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capb_pkg: shared types and constants for the coverage alpha pixel blender
// Register map, configuration bundle and the divide-by-255 helper.
// ----------------------------------------------------------------------------
package capb_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;

    // register indexes (byte address = 4 * index)
    localparam logic [IDX_W-1:0] REG_COLOR_RED     = 3'd0;
    localparam logic [IDX_W-1:0] REG_COLOR_GREEN   = 3'd1;
    localparam logic [IDX_W-1:0] REG_COLOR_BLUE    = 3'd2;
    localparam logic [IDX_W-1:0] REG_COLOR_ALPHA   = 3'd3;
    localparam logic [IDX_W-1:0] REG_CANVAS_WIDTH  = 3'd4;
    localparam logic [IDX_W-1:0] REG_CANVAS_HEIGHT = 3'd5;

    localparam logic [7:0]  COLOR_RESET = 8'hFF;
    localparam logic [12:0] DIM_RESET   = 13'd0;
    localparam logic [7:0]  FULL_SCALE  = 8'd255;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [12:0] width;
        logic [12:0] height;
    } cfg_t;

    // x / 255, truncating; exact for x up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return t[15:8];
    endfunction

endpackage

### hdl/coverage_alpha_pixel_blend_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coverage_alpha_pixel_blend_unit: glyph coverage onto RGBA8888 pixel
// Scales coverage by colour alpha, blends the colour over the canvas pixel
// and clips against the configured canvas.
// ----------------------------------------------------------------------------
//  channel   dir   signals                         carries
//  s_axis    in    s_tvalid/s_tready/s_tdata       coverage, position, pixel
//  m_axis    out   m_tvalid/m_tready/m_tdata/tuser new pixel, written flag
//  apb       in    psel/penable/pwrite/paddr/...   colour, canvas size
//
//  One pixel per clock sustained while m_tready does not stall the output.
//  Four register stages: coverage multiply, divide by 255, channel
//  multiply-add, divide by 255 and select.
//  Each stage takes a new request when it is empty or its successor moves,
//  so a stalled output holds every stage without loss.
//  Reset clears the stage valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module coverage_alpha_pixel_blend_unit
#(
    parameter int unsigned MAX_CANVAS_DIM = 4096
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [7:0] coverage, [21:8] pixel_x, [35:22] pixel_y, [43:36] dst_red,
    // [51:44] dst_green, [59:52] dst_blue, [67:60] dst_alpha, [71:68] zero
    input  logic [71:0]                  s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [7:0] new_red, [15:8] new_green, [23:16] new_blue, [31:24] new_alpha
    output logic [31:0]                  m_tdata,
    // [0] written
    output logic                         m_tuser,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [capb_pkg::ADDR_W-1:0]  paddr,
    input  logic [capb_pkg::DATA_W-1:0]  pwdata,
    output logic [capb_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    localparam int DIM_W = $clog2(MAX_CANVAS_DIM + 1);

    capb_pkg::cfg_t     cfg;
    logic [DIM_W-1:0]   width_lim;
    logic [DIM_W-1:0]   height_lim;

    logic               rdy1, rdy2, rdy3, rdy4;
    logic               in_acc;

    logic [7:0]         cov;
    logic [13:0]        px, py;
    logic               inside_next;

    // stage 1
    logic               v1_reg;
    logic [15:0]        cprod_reg;
    logic               inside1_reg;
    logic [31:0]        dst1_reg;
    // stage 2
    logic               v2_reg;
    logic [7:0]         ga_reg;
    logic               inside2_reg;
    logic [31:0]        dst2_reg;
    // stage 3
    logic               v3_reg;
    logic [15:0]        sum_r_reg, sum_g_reg, sum_b_reg;
    logic [7:0]         alpha3_reg;
    logic               wr3_reg;
    logic [31:0]        dst3_reg;
    logic [7:0]         inv_ga;
    // stage 4
    logic               v4_reg;
    logic [31:0]        pix4_reg;
    logic               wr4_reg;
    logic [31:0]        pix_next;

    capb_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // saturate canvas size to the largest supported dimension
    assign width_lim  = (32'(cfg.width) > MAX_CANVAS_DIM) ?
                        DIM_W'(MAX_CANVAS_DIM) : DIM_W'(cfg.width);
    assign height_lim = (32'(cfg.height) > MAX_CANVAS_DIM) ?
                        DIM_W'(MAX_CANVAS_DIM) : DIM_W'(cfg.height);

    assign rdy4     = !v4_reg || m_tready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign in_acc   = s_tvalid && s_tready;

    assign cov = s_tdata[7:0];
    assign px  = s_tdata[21:8];
    assign py  = s_tdata[35:22];

    assign inside_next = !px[13] && (32'(px[12:0]) < 32'(width_lim)) &&
                         !py[13] && (32'(py[12:0]) < 32'(height_lim));

    // stage 1: coverage times colour alpha, clip test
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (rdy1)
            v1_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cprod_reg   <= {8'd0, cov} * {8'd0, cfg.alpha};
            inside1_reg <= inside_next;
            dst1_reg    <= s_tdata[67:36];
        end
    end

    // stage 2: scaled coverage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (rdy2)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            ga_reg      <= capb_pkg::div255(cprod_reg);
            inside2_reg <= inside1_reg;
            dst2_reg    <= dst1_reg;
        end
    end

    // stage 3: colour * ga + dst * (255 - ga) per channel
    assign inv_ga = capb_pkg::FULL_SCALE - ga_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (rdy3)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            sum_r_reg  <= {8'd0, cfg.red}   * {8'd0, ga_reg} +
                          {8'd0, dst2_reg[7:0]}   * {8'd0, inv_ga};
            sum_g_reg  <= {8'd0, cfg.green} * {8'd0, ga_reg} +
                          {8'd0, dst2_reg[15:8]}  * {8'd0, inv_ga};
            sum_b_reg  <= {8'd0, cfg.blue}  * {8'd0, ga_reg} +
                          {8'd0, dst2_reg[23:16]} * {8'd0, inv_ga};
            alpha3_reg <= (dst2_reg[31:24] > ga_reg) ? dst2_reg[31:24] : ga_reg;
            wr3_reg    <= inside2_reg && (ga_reg != 8'd0);
            dst3_reg   <= dst2_reg;
        end
    end

    // stage 4: normalise, pass the pixel through when clipped or transparent
    assign pix_next = wr3_reg ?
                      {alpha3_reg, capb_pkg::div255(sum_b_reg),
                       capb_pkg::div255(sum_g_reg), capb_pkg::div255(sum_r_reg)} :
                      dst3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (rdy4)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy4 && v3_reg)
        begin
            pix4_reg <= pix_next;
            wr4_reg  <= wr3_reg;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = pix4_reg;
    assign m_tuser  = wr4_reg;

    // an empty output stage means the whole pipe can take a request
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input not ready while output stage is empty");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> v1_reg)
        else $error("accepted request did not enter stage 1");

    a_written_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[31:24] != 8'd0))
        else $error("written pixel with zero alpha");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && v4_reg && !m_tready) |=> (v3_reg && v4_reg))
        else $error("stalled stage lost its request");

endmodule

### hdl/capb_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capb_cfg: configuration registers
// APB-style slave holding the drawing colour and the canvas size.
// ----------------------------------------------------------------------------
module capb_cfg
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [capb_pkg::ADDR_W-1:0]  paddr,
    input  logic [capb_pkg::DATA_W-1:0]  pwdata,
    output logic [capb_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output capb_pkg::cfg_t               cfg
);

    capb_pkg::cfg_t               cfg_reg;
    logic                         wr_en;
    logic [capb_pkg::IDX_W-1:0]   idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[capb_pkg::ADDR_W-1:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.red    <= capb_pkg::COLOR_RESET;
            cfg_reg.green  <= capb_pkg::COLOR_RESET;
            cfg_reg.blue   <= capb_pkg::COLOR_RESET;
            cfg_reg.alpha  <= capb_pkg::COLOR_RESET;
            cfg_reg.width  <= capb_pkg::DIM_RESET;
            cfg_reg.height <= capb_pkg::DIM_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                capb_pkg::REG_COLOR_RED:     cfg_reg.red    <= pwdata[7:0];
                capb_pkg::REG_COLOR_GREEN:   cfg_reg.green  <= pwdata[7:0];
                capb_pkg::REG_COLOR_BLUE:    cfg_reg.blue   <= pwdata[7:0];
                capb_pkg::REG_COLOR_ALPHA:   cfg_reg.alpha  <= pwdata[7:0];
                capb_pkg::REG_CANVAS_WIDTH:  cfg_reg.width  <= pwdata[12:0];
                capb_pkg::REG_CANVAS_HEIGHT: cfg_reg.height <= pwdata[12:0];
                default: ; // drop writes beyond the map
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            capb_pkg::REG_COLOR_RED:     prdata = {24'd0, cfg_reg.red};
            capb_pkg::REG_COLOR_GREEN:   prdata = {24'd0, cfg_reg.green};
            capb_pkg::REG_COLOR_BLUE:    prdata = {24'd0, cfg_reg.blue};
            capb_pkg::REG_COLOR_ALPHA:   prdata = {24'd0, cfg_reg.alpha};
            capb_pkg::REG_CANVAS_WIDTH:  prdata = {19'd0, cfg_reg.width};
            capb_pkg::REG_CANVAS_HEIGHT: prdata = {19'd0, cfg_reg.height};
            default:                     prdata = '0;
        endcase
    end

endmodule
